// File: design/quoted_word_tokenizer_defines.svh
// assertion macros for the tokenizer
`ifndef QUOTED_WORD_TOKENIZER_DEFINES_SVH
`define QUOTED_WORD_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define QWT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("qwt assertion failed");

`define QWT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("qwt assertion failed");

`else

`define QWT_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define QWT_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: design/qwt_pkg.sv
package qwt_pkg;

    localparam int QW_DEPTH = 4;
    localparam int QW_AW    = $clog2(QW_DEPTH);

    localparam logic [6:0] LIMIT_RESET = 7'd16;
    localparam logic [6:0] WORD_CAP    = 7'd64;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_NUL    = 8'h00;

    typedef enum logic [1:0] {
        QUOTE_NONE   = 2'd0,
        QUOTE_SINGLE = 2'd1,
        QUOTE_DOUBLE = 2'd2
    } t_quote;

    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_EOW  = 2'd1,
        KIND_DONE = 2'd2
    } t_kind;

    // one queue entry: first result, plus a trailing line done when two is set
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  byte_out;
        logic [5:0]  word_index;
        logic [6:0]  word_total;
        logic        parse_error;
        logic        two;
    } t_rec;

    typedef struct packed {
        logic push;
        t_rec rec;
    } t_push;

endpackage

// File: design/qwt_item_if.sv
interface qwt_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       line_end;

    modport source (output valid, output character, output line_end, input ready);
    modport sink   (input valid, input character, input line_end, output ready);
endinterface

// File: design/qwt_result_if.sv
interface qwt_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [5:0] word_index;
    logic [6:0] word_total;
    logic       parse_error;
    logic       last;

    modport source (output valid, output kind, output byte_out, output word_index,
                    output word_total, output parse_error, output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input word_index,
                    input word_total, input parse_error, input last, output ready);
endinterface

// File: design/qwt_cfg_if.sv
interface qwt_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] word_limit;

    modport source (output valid, output word_limit, input ready);
    modport sink   (input valid, input word_limit, output ready);
endinterface

// File: design/qwt_queue.sv
`include "quoted_word_tokenizer_defines.svh"

module qwt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qwt_pkg::t_push i_push,
    input  logic          i_pop,
    output qwt_pkg::t_rec o_head,
    output logic          o_empty,
    output logic          o_full
);

    qwt_pkg::t_rec                 r_mem [qwt_pkg::QW_DEPTH];
    logic [qwt_pkg::QW_AW-1:0]     r_wr;
    logic [qwt_pkg::QW_AW-1:0]     r_rd;
    logic [qwt_pkg::QW_AW:0]       r_cnt;
    logic                          do_pop;

    assign o_full  = (r_cnt == (qwt_pkg::QW_AW+1)'(qwt_pkg::QW_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push.push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `QWT_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push.push, !o_full || do_pop)
    `QWT_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1,
        r_cnt <= (qwt_pkg::QW_AW+1)'(qwt_pkg::QW_DEPTH))

endmodule

// File: design/qwt_front.sv
`include "quoted_word_tokenizer_defines.svh"

module qwt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    qwt_item_if.sink       i_item,
    qwt_cfg_if.sink        i_cfg,
    input  logic           i_full,
    output qwt_pkg::t_push o_push
);

    logic [6:0]        r_limit;
    logic              r_inside;
    qwt_pkg::t_quote   r_quote;
    logic              r_esc;
    logic [6:0]        r_words;
    logic              r_err;

    logic              n_inside;
    qwt_pkg::t_quote   n_quote;
    logic              n_esc;
    logic [6:0]        n_words;
    logic              n_err;

    logic              accept;
    logic              is_end;
    logic              blank;
    logic              err_any;
    logic              go;
    logic [6:0]        limit;
    logic [6:0]        words_v;
    logic [5:0]        idx;
    logic [7:0]        ch;
    qwt_pkg::t_push    push;

    assign i_item.ready = !i_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_item.valid && i_item.ready;
    assign ch           = i_item.character;
    assign is_end       = i_item.line_end || (ch == qwt_pkg::CH_NUL);
    assign blank        = (ch == qwt_pkg::CH_SPACE) || (ch == qwt_pkg::CH_TAB);
    assign limit        = (r_limit > qwt_pkg::WORD_CAP) ? qwt_pkg::WORD_CAP : r_limit;
    assign err_any      = r_err || r_esc || (r_quote != qwt_pkg::QUOTE_NONE);

    always_comb begin
        n_inside = r_inside;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_words  = r_words;
        n_err    = r_err;
        go       = 1'b0;
        words_v  = r_words;
        idx      = r_words[5:0] - 6'd1;
        push     = '0;
        push.rec.kind = qwt_pkg::KIND_BYTE;

        if (is_end) begin
            push.push             = 1'b1;
            push.rec.two          = !err_any && r_inside;
            push.rec.kind         = (!err_any && r_inside) ? qwt_pkg::KIND_EOW
                                                           : qwt_pkg::KIND_DONE;
            push.rec.word_index   = (!err_any && r_inside) ? idx : 6'd0;
            push.rec.word_total   = r_words;
            push.rec.parse_error  = err_any;
            n_inside = 1'b0;
            n_quote  = qwt_pkg::QUOTE_NONE;
            n_esc    = 1'b0;
            n_words  = '0;
            n_err    = 1'b0;
        end else if (r_err) begin
            go = 1'b0;
        end else if (r_esc) begin
            n_esc               = 1'b0;
            push.push           = 1'b1;
            push.rec.byte_out   = ch;
            push.rec.word_index = idx;
        end else begin
            go = 1'b1;
            if (!r_inside) begin
                if (blank) begin
                    go = 1'b0;
                end else if (r_words >= limit) begin
                    n_err = 1'b1;
                    go    = 1'b0;
                end else begin
                    words_v = r_words + 7'd1;
                end
            end
            if (go) begin
                n_words  = words_v;
                n_inside = 1'b1;
                idx      = words_v[5:0] - 6'd1;
                push.rec.word_index = idx;
                if (r_quote == qwt_pkg::QUOTE_NONE && blank) begin
                    n_inside      = 1'b0;
                    push.push     = 1'b1;
                    push.rec.kind = qwt_pkg::KIND_EOW;
                end else if (ch == qwt_pkg::CH_BSLASH && r_quote != qwt_pkg::QUOTE_SINGLE) begin
                    n_esc = 1'b1;
                end else if (ch == qwt_pkg::CH_SQUOTE && r_quote == qwt_pkg::QUOTE_NONE) begin
                    n_quote = qwt_pkg::QUOTE_SINGLE;
                end else if (ch == qwt_pkg::CH_DQUOTE && r_quote == qwt_pkg::QUOTE_NONE) begin
                    n_quote = qwt_pkg::QUOTE_DOUBLE;
                end else if ((ch == qwt_pkg::CH_SQUOTE && r_quote == qwt_pkg::QUOTE_SINGLE) ||
                             (ch == qwt_pkg::CH_DQUOTE && r_quote == qwt_pkg::QUOTE_DOUBLE)) begin
                    n_quote = qwt_pkg::QUOTE_NONE;
                end else begin
                    push.push         = 1'b1;
                    push.rec.byte_out = ch;
                end
            end
        end

        if (!accept) begin
            push.push = 1'b0;
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= qwt_pkg::LIMIT_RESET;
            r_inside <= 1'b0;
            r_quote  <= qwt_pkg::QUOTE_NONE;
            r_esc    <= 1'b0;
            r_words  <= '0;
            r_err    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_limit <= i_cfg.word_limit;
            end
            if (accept) begin
                r_inside <= n_inside;
                r_quote  <= n_quote;
                r_esc    <= n_esc;
                r_words  <= n_words;
                r_err    <= n_err;
            end
        end
    end

    `QWT_ASSERT_IMP(a_words_cap, i_clk, i_rst_n, 1'b1, r_words <= qwt_pkg::WORD_CAP)
    `QWT_ASSERT_IMP(a_err_silent, i_clk, i_rst_n, accept && r_err && !is_end, !o_push.push)
    `QWT_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, accept && is_end,
        r_words == '0 && !r_err && !r_esc && !r_inside)

endmodule

// File: design/qwt_back.sv
`include "quoted_word_tokenizer_defines.svh"

module qwt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qwt_pkg::t_rec  i_head,
    input  logic           i_empty,
    output logic           o_pop,
    qwt_result_if.source   o_result
);

    logic            r_valid;
    qwt_pkg::t_kind  r_kind;
    logic [7:0]      r_byte;
    logic [5:0]      r_index;
    logic [6:0]      r_total;
    logic            r_perr;
    logic            r_last;
    logic            r_pend;
    logic [6:0]      r_pend_total;
    logic            r_pend_err;
    logic            load;
    logic            head_done;

    assign load      = !r_valid || o_result.ready;
    assign o_pop     = load && !r_pend && !i_empty;
    assign head_done = (i_head.kind == qwt_pkg::KIND_DONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_empty;
                r_pend  <= !i_empty && i_head.two;
            end
        end
    end

    // payload of the output stage
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_kind  <= qwt_pkg::KIND_DONE;
                r_byte  <= 8'd0;
                r_index <= 6'd0;
                r_total <= r_pend_total;
                r_perr  <= r_pend_err;
                r_last  <= 1'b1;
            end else begin
                r_kind       <= i_head.kind;
                r_byte       <= i_head.byte_out;
                r_index      <= i_head.word_index;
                r_total      <= head_done ? i_head.word_total : 7'd0;
                r_perr       <= head_done ? i_head.parse_error : 1'b0;
                r_last       <= !i_head.two;
                r_pend_total <= i_head.word_total;
                r_pend_err   <= i_head.parse_error;
            end
        end
    end

    assign o_result.valid       = r_valid;
    assign o_result.kind        = r_kind;
    assign o_result.byte_out    = r_byte;
    assign o_result.word_index  = r_index;
    assign o_result.word_total  = r_total;
    assign o_result.parse_error = r_perr;
    assign o_result.last        = r_last;

    `QWT_ASSERT_IMP(a_pend_valid, i_clk, i_rst_n, r_pend,
        r_valid && r_kind == qwt_pkg::KIND_EOW && !r_last)
    `QWT_ASSERT_NXT(a_pend_done, i_clk, i_rst_n, r_pend && o_result.ready,
        r_valid && r_kind == qwt_pkg::KIND_DONE && r_last)

endmodule

// File: design/quoted_word_tokenizer.sv
// channel    role    payload
// i_item     sink    character, line_end
// o_result   source  kind, byte_out, word_index, word_total, parse_error, last
// i_cfg      sink    word_limit
//
// one item per cycle in while the queue is not full, one result per cycle out while o_result.ready is high
// a line end inside an error-free word gives two results, an end of word then a done
// an item's result is written into the queue and then registered in the output stage
// a four-entry queue between front and back absorbs output stalls
// synchronous reset clears the line state, the queue and sets word_limit to 16
module quoted_word_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qwt_item_if.sink      i_item,
    qwt_cfg_if.sink       i_cfg,
    qwt_result_if.source  o_result
);

    qwt_pkg::t_push  push;
    qwt_pkg::t_rec   head;
    logic            empty;
    logic            full;
    logic            pop;

    qwt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push)
    );

    qwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    qwt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (empty),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
